>>> rtl/multi_channel_watchdog_unit_assert.svh
// ----------------------------------------------------------------------------
// multi_channel_watchdog_unit_assert.svh
// assertion macros shared by the watchdog checker
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_WATCHDOG_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_WATCHDOG_UNIT_ASSERT_SVH

// clocked check, masked while reset is high
`define MCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define MCW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/mcw_pkg.sv
// ----------------------------------------------------------------------------
// mcw_pkg
// shared widths, codes and types of the multi-channel watchdog
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcw_pkg;

  localparam int CHANNELS_DEF = 64;
  localparam int CH_W         = 6;
  localparam int CNT_W        = 32;
  localparam int ACT_W        = 2;

  localparam logic [CNT_W-1:0] TIMEOUT_RESET = 32'd500;

  // action codes
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START = 2'd1;
  localparam logic [ACT_W-1:0] ACT_KICK  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_END   = 2'd3;

  // scan engine to report stage
  typedef struct packed {
    logic            hit;
    logic            flush;
    logic [CH_W-1:0] channel;
  } rpt_req_t;

  // report stage back to scan engine
  typedef struct packed {
    logic accept;
    logic pending;
  } rpt_stat_t;

endpackage

>>> rtl/mcw_if.sv
// ----------------------------------------------------------------------------
// mcw_if
// command and report channels of the multi-channel watchdog
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mcw_cmd_if import mcw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [CH_W-1:0]  channel;

  modport source (output valid, action, channel, input ready);
  modport sink   (input valid, action, channel, output ready);
endinterface

interface mcw_rpt_if import mcw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  expired_channel;
  logic [CNT_W-1:0] tick_count;
  logic             last;

  modport source (output valid, expired_channel, tick_count, last, input ready);
  modport sink   (input valid, expired_channel, tick_count, last, output ready);
endinterface

>>> rtl/mcw_ram.sv
// ----------------------------------------------------------------------------
// mcw_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mcw_ctrl.sv
// ----------------------------------------------------------------------------
// mcw_ctrl
// command decode, tick counter, active bits and the per-tick channel scan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcw_ctrl import mcw_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF,
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  mcw_cmd_if.sink          cmd,
  input  logic [CNT_W-1:0] timeout,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output logic [CNT_W-1:0] ram_wdata,
  output logic [AW-1:0]    ram_raddr,
  input  logic [CNT_W-1:0] ram_rdata,
  output rpt_req_t         req,
  input  rpt_stat_t        stat,
  output logic [CNT_W-1:0] tick_count
);

  localparam int IDX_W = $clog2(CHANNELS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                state;
  logic [CNT_W-1:0]    tick_counter;
  logic [CHANNELS-1:0] active;
  logic [IDX_W-1:0]    idx;
  logic                chk_valid;
  logic [AW-1:0]       chk_addr;

  logic             cmd_fire;
  logic             in_range;
  logic [AW-1:0]    cmd_addr;
  logic             idx_end;
  logic [CNT_W-1:0] elapsed;
  logic             overdue;
  logic             stall;
  logic             scan_done;
  logic             cmd_wr;

  // command decode
  assign cmd.ready = (state == ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign in_range  = ({1'b0, cmd.channel} < (CH_W + 1)'(CHANNELS));
  assign cmd_addr  = cmd.channel[AW-1:0];
  assign cmd_wr    = cmd_fire && in_range &&
                     ((cmd.action == ACT_START) || (cmd.action == ACT_KICK));

  // overdue check on the stamp read in the previous cycle
  assign idx_end   = (idx == IDX_W'(CHANNELS));
  assign elapsed   = tick_counter - ram_rdata;
  assign overdue   = (state == ST_SCAN) && chk_valid && active[chk_addr] &&
                     (elapsed > timeout);
  assign stall     = overdue && !stat.accept;
  assign scan_done = (state == ST_SCAN) && idx_end && !chk_valid && !stat.pending;

  // report requests
  assign req.hit     = overdue;
  assign req.flush   = (state == ST_SCAN) && idx_end && !chk_valid;
  assign req.channel = CH_W'(chk_addr);
  assign tick_count  = tick_counter;

  // stamp memory access; a stalled hit re-reads its own entry
  assign ram_raddr = stall ? chk_addr : idx[AW-1:0];
  assign ram_we    = cmd_wr || (overdue && stat.accept);
  assign ram_waddr = (state == ST_SCAN) ? chk_addr : cmd_addr;
  assign ram_wdata = tick_counter;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tick_counter <= '0;
      active       <= '0;
      idx          <= '0;
      chk_valid    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            unique case (cmd.action)
              ACT_TICK: begin
                tick_counter <= tick_counter + 1'b1;
                idx          <= '0;
                chk_valid    <= 1'b0;
                state        <= ST_SCAN;
              end
              ACT_START: begin
                if (in_range) begin
                  active[cmd_addr] <= 1'b1;
                end
              end
              ACT_KICK: begin
              end
              ACT_END: begin
                if (in_range) begin
                  active[cmd_addr] <= 1'b0;
                end
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            chk_valid <= !idx_end;
            if (!idx_end) begin
              idx <= idx + 1'b1;
            end
          end
          if (scan_done) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // channel under check
  always_ff @(posedge clk) begin
    if (!stall) begin
      chk_addr <= idx[AW-1:0];
    end
  end

endmodule

>>> rtl/mcw_out.sv
// ----------------------------------------------------------------------------
// mcw_out
// holds the latest hit of a scan and drives the report register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcw_out import mcw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  rpt_req_t         req,
  input  logic [CNT_W-1:0] tick_count,
  output rpt_stat_t        stat,
  mcw_rpt_if.source        rpt
);

  logic             held_valid;
  logic [CH_W-1:0]  held_ch;
  logic             o_valid;
  logic [CH_W-1:0]  o_ch;
  logic [CNT_W-1:0] o_cnt;
  logic             o_last;

  logic load_ok;
  logic hit_take;
  logic push;
  logic flush_go;

  // a hit is known not to be last only when the next one shows up
  assign load_ok     = !o_valid || rpt.ready;
  assign stat.accept = !held_valid || load_ok;
  assign stat.pending = held_valid;
  assign hit_take    = req.hit && stat.accept;
  assign push        = hit_take && held_valid;
  assign flush_go    = req.flush && held_valid && load_ok;

  assign rpt.valid           = o_valid;
  assign rpt.expired_channel = o_ch;
  assign rpt.tick_count      = o_cnt;
  assign rpt.last            = o_last;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      if (push || flush_go) begin
        o_valid <= 1'b1;
      end else if (rpt.ready) begin
        o_valid <= 1'b0;
      end
      if (hit_take) begin
        held_valid <= 1'b1;
      end else if (flush_go) begin
        held_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (hit_take) begin
      held_ch <= req.channel;
    end
    if (push || flush_go) begin
      o_ch   <= held_ch;
      o_cnt  <= tick_count;
      o_last <= flush_go;
    end
  end

endmodule

>>> rtl/multi_channel_watchdog_unit.sv
// Multi-channel watchdog.
// cmd channel: one beat per action (tick, start, kick, end) with a channel
// number; start, kick and end act in the cycle they are taken, so cmd.ready
// stays high.
// A tick bumps the 32-bit tick counter and then scans every channel, one per
// cycle while no hit stalls, through the stamp ram (one read port, registered
// data, one write port). A tick holds cmd.ready low until the scan ends and
// its held report has been flushed.
// rpt channel: one beat per overdue channel, in ascending channel order,
// carrying the channel, the new tick count and last on the final beat of
// the tick. The first report of a tick is loaded into the report register
// when the second hit is taken or at the scan end; a stalled rpt channel stops
// the scan on the next hit and resumes as soon as the report register frees up.
// cfg_wr_en / cfg_wr_data write the timeout register; write only while idle.
// Reset clears the tick counter, all active bits and both channels; timeout
// returns to 500. Stamps need no clearing, a start always writes one.
// ----------------------------------------------------------------------------
// multi_channel_watchdog_unit
// top level: timeout register, scan engine, stamp ram and report stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_channel_watchdog_unit import mcw_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  mcw_cmd_if.sink          cmd,
  mcw_rpt_if.source        rpt
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CNT_W-1:0] timeout;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [CNT_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [CNT_W-1:0] ram_rdata;
  rpt_req_t         req;
  rpt_stat_t        stat;
  logic [CNT_W-1:0] tick_count;

  // timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout <= cfg_wr_data;
    end
  end

  // scan engine
  mcw_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .timeout   (timeout),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .req       (req),
    .stat      (stat),
    .tick_count(tick_count)
  );

  // stamp memory
  mcw_ram #(.WIDTH(CNT_W), .DEPTH(CHANNELS)) u_stamp_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // report stage
  mcw_out u_out (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .tick_count(tick_count),
    .stat      (stat),
    .rpt       (rpt)
  );

endmodule

>>> rtl/mcw_checker.sv
// ----------------------------------------------------------------------------
// mcw_checker
// port-level checks of the multi-channel watchdog, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "multi_channel_watchdog_unit_assert.svh"

module mcw_checker import mcw_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             cmd_valid,
  input logic             cmd_ready,
  input logic [ACT_W-1:0] cmd_action,
  input logic             rpt_valid,
  input logic             rpt_ready,
  input logic [CH_W-1:0]  rpt_expired_channel,
  input logic [CNT_W-1:0] rpt_tick_count,
  input logic             rpt_last
);

  // reset empties the report register
  `MCW_ASSERT_RST(a_rst_clears_rpt, rst |=> !rpt_valid, "report valid after reset")

  // a stalled report beat keeps its payload
  `MCW_ASSERT(a_rpt_hold, rpt_valid && !rpt_ready |=> rpt_valid && $stable(rpt_expired_channel) && $stable(rpt_tick_count) && $stable(rpt_last), "stalled report changed")

  // a tick starts a scan, other actions complete at once
  `MCW_ASSERT(a_tick_busy, cmd_valid && cmd_ready && cmd_action == ACT_TICK |=> !cmd_ready, "ready during scan")
  `MCW_ASSERT(a_cmd_quick, cmd_valid && cmd_ready && cmd_action != ACT_TICK |=> cmd_ready, "ready dropped after channel action")

  // reported channels exist
  `MCW_ASSERT(a_chan_range, rpt_valid |-> rpt_expired_channel < CHANNELS, "report for missing channel")

endmodule

bind multi_channel_watchdog_unit mcw_checker #(.CHANNELS(CHANNELS)) u_mcw_checker (
  .clk                (clk),
  .rst                (rst),
  .cmd_valid          (cmd.valid),
  .cmd_ready          (cmd.ready),
  .cmd_action         (cmd.action),
  .rpt_valid          (rpt.valid),
  .rpt_ready          (rpt.ready),
  .rpt_expired_channel(rpt.expired_channel),
  .rpt_tick_count     (rpt.tick_count),
  .rpt_last           (rpt.last)
);
